### hdl/tcd_pkg.sv
`timescale 1ns / 1ps
package tcd_pkg;
    typedef enum logic [2:0] {
        FN_LINE  = 3'd0,
        FN_FILL  = 3'd1,
        FN_RECT  = 3'd2,
        FN_READ  = 3'd3,
        FN_WRITE = 3'd4
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_LSETUP, S_LPIX, S_LRD, S_LWR,
        S_FROW, S_FRD, S_FWR, S_WRD, S_WWAIT, S_OUT
    } t_state;
endpackage

### hdl/tiled_canvas_line_rect_drawer_core.sv
`timescale 1ns / 1ps
// channel | dir | beat contents
// s_axis  | in  | tdata: func[2:0] start_x[14:3] start_y[26:15] end_x[38:27]
//         |     |   end_y[50:39] pen_color[54:51] word_index[67:55] word_value[99:68]
// m_axis  | out | tdata: read_value[31:0] done_func[34:32]
// One command at a time. A line takes a setup step, then per on-canvas pixel a read, a
// modify-write and a step, and per clipped pixel the step alone; an outline is four lines.
// A fill takes a bounds step, then a read and a modify-write per clamped pixel. A word read
// fetches and captures the word, a word write stores it; then the result beat is offered.
// After reset a clearing pass of one word per cycle over all STORE_WORDS words (6144 by
// default) runs first. A result waits in the output register; input is held until it leaves.
module tiled_canvas_line_rect_drawer_core #(
    parameter int CANVAS_WIDTH  = 256,
    parameter int CANVAS_HEIGHT = 192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // func, start_x, start_y, end_x, end_y,
                                        // pen_color, word_index, word_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // read_value, done_func
);
    localparam int BPR         = (CANVAS_WIDTH + 63) / 64;
    localparam int BROWS       = (CANVAS_HEIGHT + 63) / 64;
    localparam int STORE_WORDS = BPR * BROWS * 512;
    localparam int AW          = $clog2(STORE_WORDS);

    tcd_pkg::t_state r_state, n_state;

    logic [2:0]  r_func;
    logic [3:0]  r_color;
    logic [12:0] r_idx;
    logic [31:0] r_wval, r_rd;
    logic signed [12:0] r_ax, r_ay, r_bx, r_by;   // corners
    logic [1:0]  r_seg;                            // outline segment
    // line walker
    logic signed [12:0] r_x, r_y, r_x1;
    logic signed [13:0] r_dx, r_dy, r_err;
    logic        r_sx, r_sy, r_xmaj;
    logic [12:0] r_n;
    logic [AW:0] r_clr;
    logic [12:0] r_fx0;

    logic [31:0] ram_rd;
    logic        ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [31:0] ram_wd;

    tcd_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    wire accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == tcd_pkg::S_IDLE);
    assign m_axis_tvalid = (r_state == tcd_pkg::S_OUT);
    assign m_axis_tdata  = {5'd0, r_func, r_rd};

    // current pixel and its address
    logic        pix_in;
    logic [AW-1:0] pix_addr;
    logic [12:0] ux, uy;
    logic [31:0] blk;
    always_comb begin
        ux = r_x;
        uy = r_y;
        pix_in = !r_x[12] && !r_y[12] && (r_x < 13'(CANVAS_WIDTH))
                 && (r_y < 13'(CANVAS_HEIGHT));
        blk = 32'(uy >> 6) * 32'(BPR) + 32'(ux >> 6);
        pix_addr = AW'(blk * 32'd512
            + 32'(((uy & 13'h38) + ((ux & 13'h3f) >> 3)) * 13'd8) + 32'(uy & 13'd7));
    end

    logic [4:0]  shamt;
    logic [31:0] merged;
    assign shamt  = {r_x[2:0], 2'b00};
    assign merged = (ram_rd & ~(32'hf << shamt)) | (32'(r_color) << shamt);

    // segment endpoints for line or outline
    logic signed [12:0] seg_x0, seg_y0, seg_x1, seg_y1;
    always_comb begin
        seg_x0 = r_ax; seg_y0 = r_ay; seg_x1 = r_bx; seg_y1 = r_by;
        if (r_func == tcd_pkg::FN_RECT) begin
            case (r_seg)
                2'd0: begin seg_x0 = r_ax; seg_y0 = r_ay; seg_x1 = r_bx; seg_y1 = r_ay; end
                2'd1: begin seg_x0 = r_bx; seg_y0 = r_ay; seg_x1 = r_bx; seg_y1 = r_by; end
                2'd2: begin seg_x0 = r_ax; seg_y0 = r_ay; seg_x1 = r_ax; seg_y1 = r_by; end
                default: begin seg_x0 = r_ax; seg_y0 = r_by; seg_x1 = r_bx; seg_y1 = r_by; end
            endcase
        end
    end
    logic signed [13:0] ddx, ddy;
    assign ddx = 14'(seg_x1) - 14'(seg_x0);
    assign ddy = 14'(seg_y1) - 14'(seg_y0);

    // fill bounds after ordering and clamping
    logic signed [12:0] fx0, fx1, fy0, fy1;
    logic f_out;
    always_comb begin
        fx0 = (r_bx < r_ax) ? r_bx : r_ax;
        fx1 = (r_bx < r_ax) ? r_ax : r_bx;
        fy0 = (r_by < r_ay) ? r_by : r_ay;
        fy1 = (r_by < r_ay) ? r_ay : r_by;
        f_out = (fx0 >= 13'sd0 && fx0 >= 13'(CANVAS_WIDTH))
             || (fy0 >= 13'sd0 && fy0 >= 13'(CANVAS_HEIGHT)) || fx1 < 0 || fy1 < 0;
        if (fx0 < 0) fx0 = '0;
        if (fy0 < 0) fy0 = '0;
        if (fx1 >= 13'(CANVAS_WIDTH)) fx1 = 13'(CANVAS_WIDTH - 1);
        if (fy1 >= 13'(CANVAS_HEIGHT)) fy1 = 13'(CANVAS_HEIGHT - 1);
    end

    logic signed [13:0] e2;
    assign e2 = r_err + (r_xmaj ? (r_dy <<< 1) : (r_dx <<< 1));
    wire idx_ok = (32'(r_idx) < 32'(STORE_WORDS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcd_pkg::S_CLEAR: if (r_clr == (AW+1)'(STORE_WORDS - 1)) n_state = tcd_pkg::S_IDLE;
            tcd_pkg::S_IDLE: if (accept) begin
                case (s_axis_tdata[2:0])
                    tcd_pkg::FN_LINE, tcd_pkg::FN_RECT: n_state = tcd_pkg::S_LSETUP;
                    tcd_pkg::FN_FILL:  n_state = tcd_pkg::S_FROW;
                    tcd_pkg::FN_READ:  n_state = tcd_pkg::S_WRD;
                    tcd_pkg::FN_WRITE: n_state = tcd_pkg::S_WWAIT;
                    default:           n_state = tcd_pkg::S_OUT;
                endcase
            end
            tcd_pkg::S_LSETUP: n_state = tcd_pkg::S_LPIX;
            tcd_pkg::S_LPIX:   n_state = pix_in ? tcd_pkg::S_LRD : tcd_pkg::S_LWR;
            tcd_pkg::S_LRD:    n_state = tcd_pkg::S_LWR;
            tcd_pkg::S_LWR: begin
                if (r_n != 13'd1) n_state = tcd_pkg::S_LPIX;
                else if (r_func == tcd_pkg::FN_RECT && r_seg != 2'd3)
                    n_state = tcd_pkg::S_LSETUP;
                else n_state = tcd_pkg::S_OUT;
            end
            tcd_pkg::S_FROW: n_state = f_out ? tcd_pkg::S_OUT : tcd_pkg::S_FRD;
            tcd_pkg::S_FRD:  n_state = tcd_pkg::S_FWR;
            tcd_pkg::S_FWR: begin
                if (r_x != r_x1) n_state = tcd_pkg::S_FRD;
                else if (r_y != fy1) n_state = tcd_pkg::S_FRD;
                else n_state = tcd_pkg::S_OUT;
            end
            tcd_pkg::S_WRD:   n_state = tcd_pkg::S_WWAIT;
            tcd_pkg::S_WWAIT: n_state = tcd_pkg::S_OUT;
            tcd_pkg::S_OUT:   if (m_axis_tready) n_state = tcd_pkg::S_IDLE;
            default:          n_state = tcd_pkg::S_IDLE;
        endcase
    end

    // memory port
    always_comb begin
        ram_we = 1'b0;
        ram_wa = pix_addr;
        ram_wd = merged;
        ram_ra = pix_addr;
        case (r_state)
            tcd_pkg::S_CLEAR: begin
                ram_we = 1'b1; ram_wa = r_clr[AW-1:0]; ram_wd = '0;
            end
            tcd_pkg::S_LRD, tcd_pkg::S_FWR: ram_we = 1'b1;
            tcd_pkg::S_WRD: ram_ra = AW'(r_idx);
            tcd_pkg::S_WWAIT: begin
                ram_we = (r_func == tcd_pkg::FN_WRITE) && idx_ok;
                ram_wa = AW'(r_idx);
                ram_wd = r_wval;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcd_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tcd_pkg::S_CLEAR) r_clr <= r_clr + 1'b1;
        end
        case (r_state)
            tcd_pkg::S_IDLE: if (accept) begin
                r_func  <= s_axis_tdata[2:0];
                r_ax    <= 13'(signed'(s_axis_tdata[14:3]));
                r_ay    <= 13'(signed'(s_axis_tdata[26:15]));
                r_bx    <= 13'(signed'(s_axis_tdata[38:27]));
                r_by    <= 13'(signed'(s_axis_tdata[50:39]));
                r_color <= s_axis_tdata[54:51];
                r_idx   <= s_axis_tdata[67:55];
                r_wval  <= s_axis_tdata[99:68];
                r_seg   <= '0;
                r_rd    <= '0;
            end
            tcd_pkg::S_LSETUP: begin
                r_x  <= seg_x0;
                r_y  <= seg_y0;
                r_sx <= ddx[13];
                r_sy <= ddy[13];
                r_dx <= ddx[13] ? -ddx : ddx;
                r_dy <= ddy[13] ? -ddy : ddy;
                if ((ddx[13] ? -ddx : ddx) > (ddy[13] ? -ddy : ddy)) begin
                    r_xmaj <= 1'b1;
                    r_err  <= ddx[13] ? ddx : -ddx;
                    r_n    <= 13'((ddx[13] ? -ddx : ddx) + 14'sd1);
                end else begin
                    r_xmaj <= 1'b0;
                    r_err  <= ddy[13] ? ddy : -ddy;
                    r_n    <= 13'((ddy[13] ? -ddy : ddy) + 14'sd1);
                end
            end
            tcd_pkg::S_LWR: begin
                // the write of this pixel, if it is on the canvas, happened in S_LRD; now step
                r_n <= r_n - 1'b1;
                if (r_n == 13'd1) r_seg <= r_seg + 1'b1;
                if (r_xmaj) begin
                    r_x <= r_sx ? r_x - 1'b1 : r_x + 1'b1;
                    if (e2 >= 0) begin
                        r_err <= e2 - (r_dx <<< 1);
                        r_y <= r_sy ? r_y - 1'b1 : r_y + 1'b1;
                    end else r_err <= e2;
                end else begin
                    r_y <= r_sy ? r_y - 1'b1 : r_y + 1'b1;
                    if (e2 >= 0) begin
                        r_err <= e2 - (r_dy <<< 1);
                        r_x <= r_sx ? r_x - 1'b1 : r_x + 1'b1;
                    end else r_err <= e2;
                end
            end
            tcd_pkg::S_FROW: begin
                r_x <= fx0; r_fx0 <= fx0; r_x1 <= fx1; r_y <= fy0;
            end
            tcd_pkg::S_FWR: begin
                if (r_x != r_x1) r_x <= r_x + 1'b1;
                else begin
                    r_x <= r_fx0;
                    r_y <= r_y + 1'b1;
                end
            end
            tcd_pkg::S_WWAIT:
                if (r_func == tcd_pkg::FN_READ && idx_ok) r_rd <= ram_rd;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcd_pkg::S_IDLE) |-> !ram_we) else $error("write while idle");
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_func != tcd_pkg::FN_READ) |-> (r_rd == 32'd0))
        else $error("nonzero read value");
`endif
endmodule

### hdl/tcd_ram.sv
`timescale 1ns / 1ps
module tcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 6144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
